### rtl/jhrs_pkg.sv
// Shared types, constants, sine generator and microprogram of the heading-relative setpoint block.
package jhrs_pkg;

    // Parameter defaults
    localparam int START_HEADING_DEF    = 0;
    localparam int SINE_TABLE_DEPTH_DEF = 256;
    localparam int DEADBAND_DEF         = 820;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X         = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y         = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z         = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZONTAL_GAIN = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_GAIN   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN       = 4'd7;

    // Register reset values
    localparam logic signed [31:0] RST_START_X    = 32'sd0;
    localparam logic signed [31:0] RST_START_Y    = 32'sd0;
    localparam logic signed [31:0] RST_START_Z    = 32'sd65536;
    localparam logic signed [31:0] RST_MIN_HEIGHT = 32'sd0;
    localparam logic signed [31:0] RST_MAX_HEIGHT = 32'sd131072;
    localparam logic [15:0]        RST_H_GAIN     = 16'd1966;
    localparam logic [15:0]        RST_V_GAIN     = 16'd1311;
    localparam logic [15:0]        RST_T_GAIN     = 16'd104;

    // Item command codes
    localparam logic CMD_JOY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Quarter turn in binary angle units
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] axis_roll;
        logic signed [15:0] axis_pitch;
        logic signed [15:0] axis_turn;
        logic signed [15:0] axis_climb;
        logic               reset_button;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        heading;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] min_height;
        logic signed [31:0] max_height;
        logic [15:0]        horizontal_gain;
        logic [15:0]        vertical_gain;
        logic [15:0]        turn_gain;
    } cfg_t;

    // Control word fields
    typedef enum logic [2:0] {
        MUL_PITCH_HG, MUL_ROLL_HG, MUL_CLIMB_VG, MUL_TURN_TG,
        MUL_FWD_C, MUL_LAT_S, MUL_FWD_S, MUL_LAT_C
    } mul_sel_t;

    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

    typedef enum logic [2:0] {
        WR_NONE, WR_FWD, WR_LAT, WR_UP, WR_TURN, WR_DX, WR_DY
    } wr_sel_t;

    typedef enum logic {ROM_SIN, ROM_COS} rom_sel_t;

    typedef enum logic [1:0] {CAP_NONE, CAP_SIN, CAP_COS} cap_sel_t;

    typedef enum logic [2:0] {
        POS_NONE, POS_JOY, POS_Z_SUM, POS_Z_CLAMP, POS_HEAD, POS_X, POS_Y
    } pos_op_t;

    typedef enum logic [1:0] {SEQ_NEXT, SEQ_BR_JOY, SEQ_PUBLISH, SEQ_END} seq_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        wr_sel_t  wr_sel;
        rom_sel_t rom_sel;
        cap_sel_t cap_sel;
        pos_op_t  pos_op;
        seq_op_t  seq_op;
    } ucode_t;

    // Program counter
    localparam int               PC_W     = 4;
    localparam logic [PC_W-1:0]  JOY_STEP = 4'd12;

    // Microprogram: a tick runs steps 0 to 11, a joystick item steps 0 and 12.
    // Each multiplier result is registered in prod_reg, then in the accumulator, before write-back.
    function automatic ucode_t ucode_at(input logic [PC_W-1:0] pc);
        ucode_t uc;
        case (pc)
            4'd0:  uc = '{MUL_PITCH_HG, ACC_HOLD, WR_NONE, ROM_SIN, CAP_NONE, POS_NONE,
                          SEQ_BR_JOY};
            4'd1:  uc = '{MUL_ROLL_HG, ACC_LOAD, WR_NONE, ROM_COS, CAP_SIN, POS_NONE,
                          SEQ_NEXT};
            4'd2:  uc = '{MUL_CLIMB_VG, ACC_LOAD, WR_FWD, ROM_SIN, CAP_COS, POS_NONE,
                          SEQ_NEXT};
            4'd3:  uc = '{MUL_TURN_TG, ACC_LOAD, WR_LAT, ROM_SIN, CAP_NONE, POS_NONE,
                          SEQ_NEXT};
            4'd4:  uc = '{MUL_FWD_C, ACC_LOAD, WR_UP, ROM_SIN, CAP_NONE, POS_NONE,
                          SEQ_NEXT};
            4'd5:  uc = '{MUL_LAT_S, ACC_LOAD, WR_TURN, ROM_SIN, CAP_NONE, POS_Z_SUM,
                          SEQ_NEXT};
            4'd6:  uc = '{MUL_FWD_S, ACC_SUB, WR_NONE, ROM_SIN, CAP_NONE, POS_HEAD,
                          SEQ_NEXT};
            4'd7:  uc = '{MUL_LAT_C, ACC_LOAD, WR_DX, ROM_SIN, CAP_NONE, POS_Z_CLAMP,
                          SEQ_NEXT};
            4'd8:  uc = '{MUL_LAT_C, ACC_ADD, WR_NONE, ROM_SIN, CAP_NONE, POS_X,
                          SEQ_NEXT};
            4'd9:  uc = '{MUL_LAT_C, ACC_HOLD, WR_DY, ROM_SIN, CAP_NONE, POS_NONE,
                          SEQ_NEXT};
            4'd10: uc = '{MUL_LAT_C, ACC_HOLD, WR_NONE, ROM_SIN, CAP_NONE, POS_Y,
                          SEQ_NEXT};
            4'd11: uc = '{MUL_LAT_C, ACC_HOLD, WR_NONE, ROM_SIN, CAP_NONE, POS_NONE,
                          SEQ_PUBLISH};
            4'd12: uc = '{MUL_PITCH_HG, ACC_HOLD, WR_NONE, ROM_SIN, CAP_NONE, POS_JOY,
                          SEQ_END};
            default: uc = '{MUL_PITCH_HG, ACC_HOLD, WR_NONE, ROM_SIN, CAP_NONE, POS_NONE,
                            SEQ_END};
        endcase
        return uc;
    endfunction

    // Sine of a binary angle in Q1.14: fold into the first quadrant, then an
    // odd series to the eleventh power in Q30. Evaluated at elaboration only.
    function automatic logic signed [15:0] sine_q14(input logic [15:0] a);
        logic [1:0]         quad;
        logic [63:0]        r;
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        res;
        logic signed [15:0] mag;
        quad = a[15:14];
        r    = {50'd0, a[13:0]};
        if (quad[0]) begin
            r = 64'd16384 - r;
        end
        t    = (r * HALF_PI_Q30) >> 14;
        t2   = (t * t) >> 30;
        term = t;
        sum  = signed'(t);
        for (int n = 1; n <= 5; n++) begin
            term = (term * t2) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                default: term = term / 64'd110;
            endcase
            if (n[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        res = (unsigned'(sum) + 64'd32768) >> 16;
        if (res > 64'd16384) begin
            res = 64'd16384;
        end
        mag = signed'(res[15:0]);
        return quad[1] ? -mag : mag;
    endfunction

endpackage

### rtl/jhrs_sine_rom.sv
// Sine lookup table with registered read, one entry per table step.
module jhrs_sine_rom #(
    parameter int DEPTH  = jhrs_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic [ADDR_W-1:0]        addr,
    output logic signed [15:0]       data
);

    logic signed [15:0] sine_w [DEPTH];
    logic signed [15:0] data_reg;

    // Build the table from the sine generator at elaboration
    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        assign sine_w[k] = jhrs_pkg::sine_q14(16'((k * 65536) / DEPTH));
    end

    // Register the read data
    always_ff @(posedge aclk) begin
        data_reg <= sine_w[addr];
    end

    assign data = data_reg;

endmodule

### rtl/jhrs_datapath.sv
// Datapath: shared multiplier, accumulator, pose and held axes, driven by one control word a step.
module jhrs_datapath #(
    parameter int START_HEADING    = jhrs_pkg::START_HEADING_DEF,
    parameter int SINE_TABLE_DEPTH = jhrs_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int DEADBAND         = jhrs_pkg::DEADBAND_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  jhrs_pkg::ucode_t    uc,
    input  jhrs_pkg::in_item_t  item,
    input  jhrs_pkg::cfg_t      cfg,
    output jhrs_pkg::out_item_t pose
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int MUL_AW = 18;
    localparam int MUL_BW = 17;
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int ACC_W  = 36;
    localparam int FRAC   = 14;
    localparam int STEP_W = ACC_W - FRAC;

    localparam logic signed [16:0]     DB_W       = 17'(DEADBAND);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC - 1));
    localparam logic [15:0]            HEAD_RST   = 16'(START_HEADING);

    // Pose and held axes
    logic signed [31:0]       x_reg, y_reg, z_reg;
    logic [15:0]              heading_reg;
    logic signed [15:0]       roll_reg, pitch_reg, turn_ax_reg, climb_reg;

    // Working registers
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [MUL_AW-1:0] fwd_reg, lat_reg, up_reg;
    logic [15:0]              turn_reg;
    logic signed [STEP_W-1:0] dx_reg, dy_reg;
    logic signed [15:0]       s_reg, c_reg;
    logic signed [32:0]       z_sum_reg;

    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_ext, acc_next, rnd_full;
    logic signed [STEP_W-1:0] rnd;
    logic signed [32:0]       x_sum, y_sum, lo_w, hi_w;
    logic signed [31:0]       x_sat, y_sat, z_clamp;
    logic [15:0]              h_sel;
    logic [IDX_W+15:0]        idx_prod;
    logic [IDX_W-1:0]         rom_addr;
    logic signed [15:0]       rom_q;

    function automatic logic signed [15:0] dead_zone(input logic signed [15:0] a);
        logic signed [16:0] a_w;
        a_w = 17'(a);
        if (a_w > -DB_W && a_w < DB_W) begin
            return '0;
        end
        return a;
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    // Select multiplier operands
    always_comb begin
        case (uc.mul_sel)
            jhrs_pkg::MUL_PITCH_HG: begin
                mul_a = MUL_AW'(pitch_reg);
                mul_b = signed'({1'b0, cfg.horizontal_gain});
            end
            jhrs_pkg::MUL_ROLL_HG: begin
                mul_a = MUL_AW'(roll_reg);
                mul_b = signed'({1'b0, cfg.horizontal_gain});
            end
            jhrs_pkg::MUL_CLIMB_VG: begin
                mul_a = MUL_AW'(climb_reg);
                mul_b = signed'({1'b0, cfg.vertical_gain});
            end
            jhrs_pkg::MUL_TURN_TG: begin
                mul_a = MUL_AW'(turn_ax_reg);
                mul_b = signed'({1'b0, cfg.turn_gain});
            end
            jhrs_pkg::MUL_FWD_C: begin
                mul_a = fwd_reg;
                mul_b = MUL_BW'(c_reg);
            end
            jhrs_pkg::MUL_LAT_S: begin
                mul_a = lat_reg;
                mul_b = MUL_BW'(s_reg);
            end
            jhrs_pkg::MUL_FWD_S: begin
                mul_a = fwd_reg;
                mul_b = MUL_BW'(s_reg);
            end
            default: begin
                mul_a = lat_reg;
                mul_b = MUL_BW'(c_reg);
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Accumulate the registered product
    assign acc_ext = ACC_W'(prod_reg);
    always_comb begin
        case (uc.acc_op)
            jhrs_pkg::ACC_LOAD: acc_next = acc_ext;
            jhrs_pkg::ACC_ADD:  acc_next = acc_reg + acc_ext;
            jhrs_pkg::ACC_SUB:  acc_next = acc_reg - acc_ext;
            default:            acc_next = acc_reg;
        endcase
    end

    // Round the accumulator to the nearest step, ties upward
    assign rnd_full = acc_reg + ROUND_HALF;
    assign rnd      = rnd_full[ACC_W-1:FRAC];

    // Saturating horizontal updates and the height clamp
    assign x_sum = 33'(x_reg) + 33'(dx_reg);
    assign y_sum = 33'(y_reg) + 33'(dy_reg);
    assign x_sat = sat33(x_sum);
    assign y_sat = sat33(y_sum);
    assign lo_w  = 33'(cfg.min_height);
    assign hi_w  = 33'(cfg.max_height);

    always_comb begin
        if (z_sum_reg < lo_w) begin
            z_clamp = (lo_w > hi_w) ? cfg.max_height : cfg.min_height;
        end else if (z_sum_reg > hi_w) begin
            z_clamp = cfg.max_height;
        end else begin
            z_clamp = z_sum_reg[31:0];
        end
    end

    // Table index for sine or cosine of the held heading
    assign h_sel    = (uc.rom_sel == jhrs_pkg::ROM_COS) ? heading_reg + jhrs_pkg::QUARTER_TURN
                                                         : heading_reg;
    assign idx_prod = {{IDX_W{1'b0}}, h_sel} * (IDX_W+16)'(SINE_TABLE_DEPTH);
    assign rom_addr = idx_prod[IDX_W+15:16];

    jhrs_sine_rom #(
        .DEPTH  (SINE_TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_q)
    );

    // Working registers advance on enabled steps only
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            case (uc.wr_sel)
                jhrs_pkg::WR_FWD:  fwd_reg  <= rnd[MUL_AW-1:0];
                jhrs_pkg::WR_LAT:  lat_reg  <= rnd[MUL_AW-1:0];
                jhrs_pkg::WR_UP:   up_reg   <= rnd[MUL_AW-1:0];
                jhrs_pkg::WR_TURN: turn_reg <= rnd[15:0];
                jhrs_pkg::WR_DX:   dx_reg   <= rnd;
                jhrs_pkg::WR_DY:   dy_reg   <= rnd;
                default: ;
            endcase
            case (uc.cap_sel)
                jhrs_pkg::CAP_SIN: s_reg <= rom_q;
                jhrs_pkg::CAP_COS: c_reg <= rom_q;
                default: ;
            endcase
            if (uc.pos_op == jhrs_pkg::POS_Z_SUM) begin
                z_sum_reg <= 33'(z_reg) + 33'(up_reg);
            end
        end
    end

    // Pose and held axes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= jhrs_pkg::RST_START_X;
            y_reg       <= jhrs_pkg::RST_START_Y;
            z_reg       <= jhrs_pkg::RST_START_Z;
            heading_reg <= HEAD_RST;
            roll_reg    <= '0;
            pitch_reg   <= '0;
            turn_ax_reg <= '0;
            climb_reg   <= '0;
        end else if (en) begin
            case (uc.pos_op)
                jhrs_pkg::POS_JOY: begin
                    if (item.reset_button) begin
                        x_reg       <= cfg.start_x;
                        y_reg       <= cfg.start_y;
                        z_reg       <= cfg.start_z;
                        heading_reg <= HEAD_RST;
                    end
                    roll_reg    <= dead_zone(item.axis_roll);
                    pitch_reg   <= dead_zone(item.axis_pitch);
                    turn_ax_reg <= dead_zone(item.axis_turn);
                    climb_reg   <= dead_zone(item.axis_climb);
                end
                jhrs_pkg::POS_Z_CLAMP: z_reg       <= z_clamp;
                jhrs_pkg::POS_HEAD:    heading_reg <= heading_reg + turn_reg;
                jhrs_pkg::POS_X:       x_reg       <= x_sat;
                jhrs_pkg::POS_Y:       y_reg       <= y_sat;
                default: ;
            endcase
        end
    end

    assign pose.pos_x   = x_reg;
    assign pose.pos_y   = y_reg;
    assign pose.pos_z   = z_reg;
    assign pose.heading = heading_reg;

endmodule

### rtl/joystick_heading_relative_setpoint.sv
// Top level: configuration registers, microprogram sequencer, input and result handshakes.
//
// Holds an x/y/z setpoint in Q15.16 metres and a 16-bit binary-angle heading, moved by four
// Q1.14 stick axes. A joystick item (cmd 0) latches the axes after the deadband and, with its
// reset button set, restores the start pose; it yields no result, and the block takes no new
// item until it has run steps 0 and 12 of the microprogram. A tick item (cmd 1) runs a
// twelve-step microprogram around one shared 18 x 17 multiplier and one accumulator:
// body step, rotation by the heading held before the tick through a registered sine table,
// saturating x/y update, z clamp and heading update. Its result is published at its last
// step, and no new item is taken before that step is through. The result sits in an
// output register, so the next item is accepted while it waits; only a second tick finding
// that register still full holds at its last step. Configuration writes are always taken and
// should be made while the block is idle.
module joystick_heading_relative_setpoint #(
    parameter int START_HEADING    = jhrs_pkg::START_HEADING_DEF,
    parameter int SINE_TABLE_DEPTH = jhrs_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int DEADBAND         = jhrs_pkg::DEADBAND_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  jhrs_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output jhrs_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jhrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jhrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    jhrs_pkg::cfg_t                 cfg_reg;
    jhrs_pkg::in_item_t             item_reg;
    jhrs_pkg::out_item_t            out_reg, out_next;
    jhrs_pkg::out_item_t            pose;
    jhrs_pkg::ucode_t               uc;
    logic                           busy_reg, busy_next;
    logic [jhrs_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           stall, step_en, publish;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy_reg;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x         <= jhrs_pkg::RST_START_X;
            cfg_reg.start_y         <= jhrs_pkg::RST_START_Y;
            cfg_reg.start_z         <= jhrs_pkg::RST_START_Z;
            cfg_reg.min_height      <= jhrs_pkg::RST_MIN_HEIGHT;
            cfg_reg.max_height      <= jhrs_pkg::RST_MAX_HEIGHT;
            cfg_reg.horizontal_gain <= jhrs_pkg::RST_H_GAIN;
            cfg_reg.vertical_gain   <= jhrs_pkg::RST_V_GAIN;
            cfg_reg.turn_gain       <= jhrs_pkg::RST_T_GAIN;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                jhrs_pkg::CFG_START_X:         cfg_reg.start_x         <= signed'(cfg_data);
                jhrs_pkg::CFG_START_Y:         cfg_reg.start_y         <= signed'(cfg_data);
                jhrs_pkg::CFG_START_Z:         cfg_reg.start_z         <= signed'(cfg_data);
                jhrs_pkg::CFG_MIN_HEIGHT:      cfg_reg.min_height      <= signed'(cfg_data);
                jhrs_pkg::CFG_MAX_HEIGHT:      cfg_reg.max_height      <= signed'(cfg_data);
                jhrs_pkg::CFG_HORIZONTAL_GAIN: cfg_reg.horizontal_gain <= cfg_data[15:0];
                jhrs_pkg::CFG_VERTICAL_GAIN:   cfg_reg.vertical_gain   <= cfg_data[15:0];
                jhrs_pkg::CFG_TURN_GAIN:       cfg_reg.turn_gain       <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Decode the current step; hold the publish step while the output is full and m_ready is low
    assign uc      = jhrs_pkg::ucode_at(pc_reg);
    assign stall   = (uc.seq_op == jhrs_pkg::SEQ_PUBLISH) && out_valid_reg && !m_ready;
    assign step_en = busy_reg && !stall;
    assign publish = step_en && (uc.seq_op == jhrs_pkg::SEQ_PUBLISH);

    // Sequencer and result register next values
    always_comb begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        if (!busy_reg) begin
            if (s_valid) begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end else if (!stall) begin
            unique case (uc.seq_op)
                jhrs_pkg::SEQ_NEXT: pc_next = pc_reg + 1'b1;
                jhrs_pkg::SEQ_BR_JOY: begin
                    pc_next = (item_reg.cmd == jhrs_pkg::CMD_JOY) ? jhrs_pkg::JOY_STEP
                                                                  : pc_reg + 1'b1;
                end
                jhrs_pkg::SEQ_PUBLISH: begin
                    busy_next      = 1'b0;
                    out_valid_next = 1'b1;
                    out_next       = pose;
                end
                jhrs_pkg::SEQ_END: busy_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the accepted item and the published pose
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        out_reg <= out_next;
    end

    jhrs_datapath #(
        .START_HEADING    (START_HEADING),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .DEADBAND         (DEADBAND)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (step_en),
        .uc      (uc),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .pose    (pose)
    );

    // A transfer starts the program at its first step
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (busy_reg && pc_reg == '0))
        else $error("program did not start at step zero after input transfer");

    // The step counter stays within the program
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pc_reg <= jhrs_pkg::JOY_STEP))
        else $error("step counter beyond the program");

    // Publishing always presents a result
    a_publish: assert property (@(posedge aclk) disable iff (!aresetn)
        publish |=> m_valid)
        else $error("publish step left the output empty");

    // A joystick item never raises a result
    a_joy_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && uc.seq_op == jhrs_pkg::SEQ_END && !m_valid) |=> !m_valid)
        else $error("joystick item produced a result");

    // The publish step is reached only by a tick
    a_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        publish |-> (item_reg.cmd == jhrs_pkg::CMD_TICK))
        else $error("result published for a joystick item");

endmodule
